### rtl/triangle_mesh_height_lookup_macros.svh
// assertion macros used by the checker file
`ifndef TRIANGLE_MESH_HEIGHT_LOOKUP_MACROS_SVH
`define TRIANGLE_MESH_HEIGHT_LOOKUP_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define TMHL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define TMHL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/tmhl_pkg.sv
`default_nettype none
package tmhl_pkg;

  // table sizes and fixed point
  localparam int VERTEX_DEPTH = 1024;
  localparam int INDEX_DEPTH  = 4096;
  localparam int FRAC_BITS    = 16;
  localparam int VERTEX_AW    = $clog2(VERTEX_DEPTH);
  localparam int INDEX_AW     = $clog2(INDEX_DEPTH);

  // field widths
  localparam int FUNC_W  = 2;
  localparam int ADDR_W  = 12;
  localparam int COORD_W = 32;
  localparam int REF_W   = 10;
  localparam int COUNT_W = 13;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_VERTEX = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INDEX  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  // register map
  localparam int PADDR_W = 3;
  localparam logic REG_INDEX_COUNT = 1'b0;

  // answer on a miss: -10.0
  localparam logic signed [COORD_W-1:0] MISS_HEIGHT = -(32'sd10 <<< FRAC_BITS);

  // largest |denominator| counted as degenerate, in units of 2^-2F
  localparam longint unsigned DEGEN_LIMIT =
    ((64'd1 << (2 * FRAC_BITS)) - 64'd1) / 64'd1000000;

endpackage
`default_nettype wire

### rtl/tmhl_if.sv
`default_nettype none
interface tmhl_in_if;
  import tmhl_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic [ADDR_W-1:0]          addr;
  logic signed [COORD_W-1:0]  coord_x;
  logic signed [COORD_W-1:0]  coord_height;
  logic signed [COORD_W-1:0]  coord_z;
  logic [REF_W-1:0]           vertex_ref;
  modport source (output valid, func, addr, coord_x, coord_height, coord_z, vertex_ref,
                  input ready);
  modport sink (input valid, func, addr, coord_x, coord_height, coord_z, vertex_ref,
                output ready);
endinterface

interface tmhl_out_if;
  import tmhl_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  height;
  logic                       hit;
  modport source (output valid, height, hit, input ready);
  modport sink (input valid, height, hit, output ready);
endinterface
`default_nettype wire

### rtl/triangle_mesh_height_lookup.sv
// Mesh height lookup. Func 0 words load a vertex (x, height, z) and func 1 words load one
// index list entry; neither yields a result. A func 2 word queries the ground point (x, z):
// the triangles are walked in list order, fetched from the index and vertex memories and
// tested against the point with one shared multiplier. A triangle that does not hold the
// point, or holds it but is degenerate, is skipped. The first holding, non-degenerate
// triangle goes on to the interpolation products, a bit-serial division of a 104-bit
// numerator, and rounding and output; if no triangle qualifies, the query misses. The
// worst case walks 1365 triangles that all hold the point but are degenerate. A finished
// result waits in the output register while new words are taken.
`default_nettype none
module triangle_mesh_height_lookup (
  input  wire logic                          clk,
  input  wire logic                          rst,
  tmhl_in_if.sink                            item,
  tmhl_out_if.source                         result,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tmhl_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import tmhl_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_RND   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  localparam logic [2:0] D_NONE = 3'd0;
  localparam logic [2:0] D_C0   = 3'd1;
  localparam logic [2:0] D_C1   = 3'd2;
  localparam logic [2:0] D_C2   = 3'd3;
  localparam logic [2:0] D_DEN  = 3'd4;
  localparam logic [2:0] D_N1   = 3'd5;
  localparam logic [2:0] D_N2   = 3'd6;

  localparam int OPW = 36;
  localparam int PW  = 2 * OPW;
  localparam int NW  = 70;
  localparam int AW  = 104;
  localparam int LOW = 35;

  logic [2:0]                state;
  logic [2:0]                fc;
  logic [4:0]                mi;
  logic [6:0]                dcnt;
  logic [COUNT_W-1:0]        index_count;
  logic [COUNT_W-1:0]        cnt_eff;
  logic [COUNT_W-1:0]        ibase;
  logic signed [COORD_W-1:0] px, pz;
  logic signed [COORD_W-1:0] vx [3];
  logic signed [COORD_W-1:0] vz [3];
  logic signed [COORD_W-1:0] vh [3];
  logic signed [NW-1:0]      c0, c1, c2, den, n1, n2, n3;

  // memories
  logic [3*COORD_W-1:0] vmem [VERTEX_DEPTH];
  logic [REF_W-1:0]     imem [INDEX_DEPTH];
  logic [3*COORD_W-1:0] vrd;
  logic [REF_W-1:0]     ird;
  logic [INDEX_AW-1:0]  iaddr;
  logic                 acc_in, vwe, iwe;

  // multiplier pipe
  logic signed [OPW-1:0] ma, mb;
  logic                  m_clr, m_sub, m_hi;
  logic [2:0]            m_dst;
  logic signed [PW-1:0]  prod;
  logic                  pv, pclr, psub, phi;
  logic [2:0]            pdst;
  logic signed [AW-1:0]  acc, acc_base, addend, acc_next;

  // divider
  logic [AW-1:0]     nq;
  logic [67:0]       ad;
  logic [68:0]       rem;
  logic [68:0]       rs;
  logic              neg;
  logic              qbit;
  logic              rnd;
  logic [AW-1:0]     qr;

  // outputs
  logic                      ovalid, ohit, res_hit, ld_out;
  logic signed [COORD_W-1:0] oh, res_h;

  // crossing test and degenerate test
  logic                  cpos, cneg, degen;
  logic signed [NW-1:0]  den_abs;
  logic                  more_tri;

  function automatic logic signed [OPW-1:0] df(input logic signed [COORD_W-1:0] a,
                                               input logic signed [COORD_W-1:0] b);
    df = OPW'(a) - OPW'(b);
  endfunction

  function automatic logic signed [OPW-1:0] lo_part(input logic signed [NW-1:0] n);
    lo_part = {1'b0, n[LOW-1:0]};
  endfunction

  function automatic logic signed [OPW-1:0] hi_part(input logic signed [NW-1:0] n);
    hi_part = {n[NW-1], n[NW-1:LOW]};
  endfunction

  // apb register port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_INDEX_COUNT) begin
      prdata = 32'(index_count);
    end
  end

  assign cnt_eff = (32'(index_count) > INDEX_DEPTH) ? COUNT_W'(INDEX_DEPTH) : index_count;

  // input handshake and writes
  assign item.ready = (state == S_IDLE);
  assign acc_in = item.valid && item.ready;
  assign vwe = acc_in && (item.func == FUNC_VERTEX) && (32'(item.addr) < VERTEX_DEPTH);
  assign iwe = acc_in && (item.func == FUNC_INDEX) && (32'(item.addr) < INDEX_DEPTH);
  assign iaddr = ibase[INDEX_AW-1:0] + INDEX_AW'(fc);

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[item.addr[VERTEX_AW-1:0]] <= {item.coord_x, item.coord_height, item.coord_z};
    end
    vrd <= vmem[ird[VERTEX_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (iwe) begin
      imem[item.addr[INDEX_AW-1:0]] <= item.vertex_ref;
    end
    ird <= imem[iaddr];
  end

  // operand selection for each product step
  always_comb begin
    ma = '0;
    mb = '0;
    m_clr = 1'b0;
    m_sub = 1'b0;
    m_hi = 1'b0;
    m_dst = D_NONE;
    case (mi)
      5'd0: begin ma = df(vx[1], vx[0]); mb = df(vz[0], pz); m_clr = 1'b1; end
      5'd1: begin ma = df(vz[1], vz[0]); mb = df(vx[0], px); m_sub = 1'b1; m_dst = D_C0; end
      5'd2: begin ma = df(vx[2], vx[1]); mb = df(vz[1], pz); m_clr = 1'b1; end
      5'd3: begin ma = df(vz[2], vz[1]); mb = df(vx[1], px); m_sub = 1'b1; m_dst = D_C1; end
      5'd4: begin ma = df(vx[0], vx[2]); mb = df(vz[2], pz); m_clr = 1'b1; end
      5'd5: begin ma = df(vz[0], vz[2]); mb = df(vx[2], px); m_sub = 1'b1; m_dst = D_C2; end
      5'd6: begin ma = df(vz[1], vz[2]); mb = df(vx[0], vx[2]); m_clr = 1'b1; end
      5'd7: begin ma = df(vx[2], vx[1]); mb = df(vz[0], vz[2]); m_dst = D_DEN; end
      5'd8: begin ma = df(vz[1], vz[2]); mb = df(px, vx[2]); m_clr = 1'b1; end
      5'd9: begin ma = df(vx[2], vx[1]); mb = df(pz, vz[2]); m_dst = D_N1; end
      5'd10: begin ma = df(vz[2], vz[0]); mb = df(px, vx[2]); m_clr = 1'b1; end
      5'd11: begin ma = df(vx[0], vx[2]); mb = df(pz, vz[2]); m_dst = D_N2; end
      5'd12: begin ma = OPW'(vh[0]); mb = lo_part(n1); m_clr = 1'b1; end
      5'd13: begin ma = OPW'(vh[0]); mb = hi_part(n1); m_hi = 1'b1; end
      5'd14: begin ma = OPW'(vh[1]); mb = lo_part(n2); end
      5'd15: begin ma = OPW'(vh[1]); mb = hi_part(n2); m_hi = 1'b1; end
      5'd16: begin ma = OPW'(vh[2]); mb = lo_part(n3); end
      5'd17: begin ma = OPW'(vh[2]); mb = hi_part(n3); m_hi = 1'b1; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // accumulate the registered product
  always_comb begin
    addend = phi ? (AW'(prod) <<< LOW) : AW'(prod);
    acc_base = pclr ? '0 : acc;
    acc_next = psub ? (acc_base - addend) : (acc_base + addend);
  end

  // containment and degenerate tests
  always_comb begin
    cpos = (c0 > 0) || (c1 > 0) || (c2 > 0);
    cneg = (c0 < 0) || (c1 < 0) || (c2 < 0);
    den_abs = den[NW-1] ? -den : den;
    degen = (den_abs <= NW'(DEGEN_LIMIT));
    more_tri = ({1'b0, ibase} + 14'd6) <= {1'b0, cnt_eff};
  end

  // divider step and rounding
  always_comb begin
    rs = {rem[67:0], nq[AW-1]};
    qbit = (rs >= {1'b0, ad});
    rnd = ({rem[67:0], 1'b0} >= {1'b0, ad});
    qr = nq + AW'(rnd);
  end

  // output register load
  assign ld_out = (state == S_FIN) && (!ovalid || result.ready);

  // product pipe
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    pclr <= m_clr;
    psub <= m_sub;
    phi <= m_hi;
    pdst <= m_dst;
    if (pv) begin
      acc <= acc_next;
      case (pdst)
        D_C0: c0 <= acc_next[NW-1:0];
        D_C1: c1 <= acc_next[NW-1:0];
        D_C2: c2 <= acc_next[NW-1:0];
        D_DEN: den <= acc_next[NW-1:0];
        D_N1: n1 <= acc_next[NW-1:0];
        D_N2: n2 <= acc_next[NW-1:0];
        default: ;
      endcase
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      index_count <= '0;
      ovalid <= 1'b0;
      pv <= 1'b0;
      fc <= '0;
      mi <= '0;
      dcnt <= '0;
      ibase <= '0;
    end else begin
      pv <= (state == S_MUL);
      if (psel && penable && pwrite && pready && (paddr[PADDR_W-1:2] == REG_INDEX_COUNT)) begin
        index_count <= pwdata[COUNT_W-1:0];
      end
      if (ld_out) begin
        ovalid <= 1'b1;
      end else if (ovalid && result.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc_in && (item.func == FUNC_QUERY)) begin
            px <= item.coord_x;
            pz <= item.coord_z;
            ibase <= '0;
            fc <= '0;
            if (cnt_eff >= COUNT_W'(3)) begin
              state <= S_FETCH;
            end else begin
              res_h <= MISS_HEIGHT;
              res_hit <= 1'b0;
              state <= S_FIN;
            end
          end
        end
        S_FETCH: begin
          fc <= fc + 3'd1;
          if (fc == 3'd2) begin
            {vx[0], vh[0], vz[0]} <= vrd;
          end
          if (fc == 3'd3) begin
            {vx[1], vh[1], vz[1]} <= vrd;
          end
          if (fc == 3'd4) begin
            {vx[2], vh[2], vz[2]} <= vrd;
            mi <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mi == 5'd5 || mi == 5'd11 || mi == 5'd17) begin
            state <= S_DRAIN;
          end else begin
            mi <= mi + 5'd1;
          end
        end
        S_DRAIN: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (mi == 5'd5 || mi == 5'd11) begin
            if ((mi == 5'd5 && cpos && cneg) || (mi == 5'd11 && degen)) begin
              // next triangle or miss
              ibase <= ibase + COUNT_W'(3);
              fc <= '0;
              if (more_tri) begin
                state <= S_FETCH;
              end else begin
                res_h <= MISS_HEIGHT;
                res_hit <= 1'b0;
                state <= S_FIN;
              end
            end else begin
              if (mi == 5'd11) begin
                n3 <= den - n1 - n2;
              end
              mi <= mi + 5'd1;
              state <= S_MUL;
            end
          end else begin
            // numerator complete: set up the division
            neg <= acc[AW-1] ^ den[NW-1];
            nq <= acc[AW-1] ? -acc : acc;
            ad <= den_abs[67:0];
            rem <= '0;
            dcnt <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= qbit ? (rs - {1'b0, ad}) : rs;
          nq <= {nq[AW-2:0], qbit};
          dcnt <= dcnt + 7'd1;
          if (dcnt == 7'(AW - 1)) begin
            state <= S_RND;
          end
        end
        S_RND: begin
          res_hit <= 1'b1;
          if (!neg) begin
            res_h <= (qr > AW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : qr[31:0];
          end else begin
            res_h <= (qr > AW'(32'h8000_0000)) ? 32'sh8000_0000 : -qr[31:0];
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (ld_out) begin
            oh <= res_h;
            ohit <= res_hit;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid = ovalid;
  assign result.height = oh;
  assign result.hit = ohit;

endmodule
`default_nettype wire

### rtl/tmhl_checker.sv
`default_nettype none
`include "triangle_mesh_height_lookup_macros.svh"
module tmhl_checker (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  in_valid,
  input wire logic                                  in_ready,
  input wire logic [tmhl_pkg::FUNC_W-1:0]           in_func,
  input wire logic                                  out_valid,
  input wire logic                                  out_ready,
  input wire logic signed [tmhl_pkg::COORD_W-1:0]   out_height,
  input wire logic                                  out_hit
);
  import tmhl_pkg::*;

  // a stalled result holds
  `TMHL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_height) && $stable(out_hit), "result changed while stalled")

  // a miss always reports -10.0
  `TMHL_ASSERT_NOW(a_miss_height, out_valid && !out_hit, out_height == MISS_HEIGHT, "miss height wrong")

  // a query keeps the input closed on the next cycle
  `TMHL_ASSERT_NEXT(a_query_busy, in_valid && in_ready && in_func == FUNC_QUERY, !in_ready, "query did not block input")

  // a write never makes a result
  `TMHL_ASSERT_NEXT(a_write_quiet, in_valid && in_ready && in_func != FUNC_QUERY && !out_valid, !out_valid, "write produced a result")

endmodule

bind triangle_mesh_height_lookup tmhl_checker u_tmhl_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(item.valid),
  .in_ready(item.ready),
  .in_func(item.func),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .out_height(result.height),
  .out_hit(result.hit)
);
`default_nettype wire
